/* src/pgf_pkg.sv */
// ----------------------------------------------------------------------------
// pgf_pkg
// shared constants, types and helpers of the potential gradient field unit
// ----------------------------------------------------------------------------
package pgf_pkg;

    // grid limits and potential width
    localparam int MAX_X     = 16;
    localparam int MAX_Y     = 16;
    localparam int MAX_Z     = 16;
    localparam int POT_WIDTH = 24;

    // fixed widths of the interface fields
    localparam int POS_W    = 4;
    localparam int IN_POT_W = 24;
    localparam int CNT_W    = 5;
    localparam int INV_W    = 16;
    localparam int FIELD_W  = 32;
    localparam int CFG_IDX_W = 2;

    // grid addressing, y major, then x, then z
    localparam int X_W    = $clog2(MAX_X);
    localparam int Y_W    = $clog2(MAX_Y);
    localparam int Z_W    = $clog2(MAX_Z);
    localparam int ADDR_W = X_W + Y_W + Z_W;
    localparam int DEPTH  = 1 << ADDR_W;

    // one memory word: {fixed, weighting, drift}
    localparam int WORD_W = 2 * POT_WIDTH + 1;

    // gradient datapath widths
    localparam int DIFF_W  = POT_WIDTH + 1;
    localparam int DCL_W   = (DIFF_W > 42) ? 42 : DIFF_W;
    localparam int PROD_W  = DCL_W + INV_W + 1;
    localparam int SHIFT   = 8;

    localparam longint POT_MAX  = (64'sd1 <<< (POT_WIDTH - 1)) - 64'sd1;
    localparam longint POT_MIN  = -POT_MAX - 64'sd1;
    localparam longint DIFF_LIM = 64'sd1 <<< 40;
    localparam longint FLD_MAX  = 64'sd2147483647;
    localparam longint FLD_MIN  = -64'sd2147483648;

    // opcodes
    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_COMPUTE = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_X_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_Y_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_Z_COUNT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INV     = 2'd3;

    typedef logic signed [POT_WIDTH-1:0] pot_t;
    typedef logic signed [FIELD_W-1:0]   field_t;
    typedef logic [ADDR_W-1:0]           addr_t;

    // control that travels beside the data in every stage
    typedef struct packed {
        logic valid;
        logic compute;
        logic live;
        logic bottom;
    } meta_t;

    // one result transfer
    typedef struct packed {
        logic   computed;
        field_t weight_ez;
        field_t weight_ey;
        field_t weight_ex;
        field_t drift_ez;
        field_t drift_ey;
        field_t drift_ex;
    } res_t;

    // count register write: zero acts as one, above the grid acts as the grid
    function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] v,
                                                     input int maxv);
        logic [CNT_W-1:0] r;
        r = v;
        if (v == '0)
            r = CNT_W'(1);
        else if (int'(v) > maxv)
            r = CNT_W'(maxv);
        return r;
    endfunction

    function automatic addr_t make_addr(input logic [CNT_W-1:0] x,
                                        input logic [CNT_W-1:0] y,
                                        input logic [CNT_W-1:0] z);
        logic [CNT_W+X_W-1:0] xw;
        logic [CNT_W+Y_W-1:0] yw;
        logic [CNT_W+Z_W-1:0] zw;
        xw = (CNT_W + X_W)'(x);
        yw = (CNT_W + Y_W)'(y);
        zw = (CNT_W + Z_W)'(z);
        return {yw[Y_W-1:0], xw[X_W-1:0], zw[Z_W-1:0]};
    endfunction

    // loaded value saturated to the store width
    function automatic pot_t sat_pot(input logic signed [IN_POT_W-1:0] v);
        longint w;
        w = longint'(v);
        if (w > POT_MAX)
            w = POT_MAX;
        else if (w < POT_MIN)
            w = POT_MIN;
        return POT_WIDTH'(w);
    endfunction

endpackage

/* src/pgf_ram.sv */
// ----------------------------------------------------------------------------
// pgf_ram
// generic memory, one write port and one read port with registered read data
// ----------------------------------------------------------------------------
module pgf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* src/pgf_lane.sv */
// ----------------------------------------------------------------------------
// pgf_lane
// one field component: difference, scale by inverse spacing, floor and saturate
// ----------------------------------------------------------------------------
module pgf_lane (
    input  logic                      clk,
    input  logic                      en,
    input  pgf_pkg::pot_t             centre,
    input  pgf_pkg::pot_t             neighbour,
    input  logic [pgf_pkg::INV_W-1:0] inv,
    output pgf_pkg::field_t           q
);
    import pgf_pkg::*;

    logic signed [DCL_W-1:0]  diff_reg;
    logic signed [DCL_W-1:0]  diff_next;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    field_t                   q_reg;
    field_t                   q_next;

    // neighbour minus centre, limited to the range the scaling expects
    always_comb
    begin
        longint d;
        d = longint'(neighbour) - longint'(centre);
        if (d > DIFF_LIM)
            d = DIFF_LIM;
        else if (d < -DIFF_LIM)
            d = -DIFF_LIM;
        diff_next = DCL_W'(d);
    end

    assign prod_next = PROD_W'(diff_reg) * PROD_W'($signed({1'b0, inv}));

    // arithmetic shift gives floor rounding
    always_comb
    begin
        longint s;
        s = longint'(prod_reg >>> SHIFT);
        if (s > FLD_MAX)
            s = FLD_MAX;
        else if (s < FLD_MIN)
            s = FLD_MIN;
        q_next = FIELD_W'(s);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            diff_reg <= diff_next;
            prod_reg <= prod_next;
            q_reg    <= q_next;
        end
    end

    assign q = q_reg;

endmodule

/* src/pgf_skid.sv */
// ----------------------------------------------------------------------------
// pgf_skid
// output register with one skid entry between the pipeline and the result bus
// ----------------------------------------------------------------------------
module pgf_skid (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  pgf_pkg::res_t push_data,
    output logic          room,
    output logic          out_valid,
    input  logic          out_ready,
    output pgf_pkg::res_t out_data
);
    import pgf_pkg::*;

    logic out_valid_reg;
    logic skid_valid_reg;
    res_t out_data_reg;
    res_t skid_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_ready)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || out_ready)
                out_valid_reg <= 1'b1;
            else
                skid_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_ready)
                out_data_reg <= skid_data_reg;
        end
        else if (push)
        begin
            if (!out_valid_reg || out_ready)
                out_data_reg <= push_data;
            else
                skid_data_reg <= push_data;
        end
    end

    assign room      = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

/* src/potential_gradient_field_unit.sv */
// ----------------------------------------------------------------------------
// potential_gradient_field_unit
// Holds a 3D grid of drift and weighting potentials with a fixed-boundary flag
// per point and answers compute requests with both electric fields, taken as
// negative backward differences scaled by the reciprocal grid spacing. Load
// transfers (tuser = 0) write one point; compute transfers (tuser = 1) give one
// result transfer each, loads give none. x and z neighbours wrap over the
// configured counts, y uses the row below; on row zero only fixed points are
// computed and their y components are zero. Requests outside the counts and
// unfixed row-zero points return zeros with the computed flag clear. A point
// must be loaded before a compute reads it. The unit takes one transfer every
// clock cycle unless stalled: the grid is held in four identical memory
// copies, each written by every load and each serving one of the four reads
// a compute needs (centre, x, y and z neighbour), so no memory port is shared.
// A result passes memory read, difference, multiply, floor and saturate, and
// the output register before it shows on the master side. Back-pressure stalls
// the whole pipeline only once the one-entry skid behind the output register
// is full. Configuration writes are always ready and take effect at once;
// they are meant for an idle unit. The grid needs no clearing after reset.
// ----------------------------------------------------------------------------
module potential_gradient_field_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    // request side
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // pos_x[3:0], pos_y[7:4], pos_z[11:8], drift_potential[35:12],
    // weighting_potential[59:36], boundary_fixed[60], zero fill [63:61]
    input  logic [63:0]                   s_tdata,
    // opcode[0]
    input  logic [0:0]                    s_tuser,
    // result side
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // drift_ex[31:0], drift_ey[63:32], drift_ez[95:64],
    // weight_ex[127:96], weight_ey[159:128], weight_ez[191:160]
    output logic [191:0]                  m_tdata,
    // computed[0]
    output logic [0:0]                    m_tuser,
    // configuration writes
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [pgf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pgf_pkg::INV_W-1:0]     cfg_data
);
    import pgf_pkg::*;

    // configuration, counts already clamped to the grid
    logic [CNT_W-1:0] x_count_reg;
    logic [CNT_W-1:0] y_count_reg;
    logic [CNT_W-1:0] z_count_reg;
    logic [INV_W-1:0] inv_reg;

    // request fields
    logic                       in_op;
    logic [POS_W-1:0]           in_x;
    logic [POS_W-1:0]           in_y;
    logic [POS_W-1:0]           in_z;
    logic signed [IN_POT_W-1:0] in_drift;
    logic signed [IN_POT_W-1:0] in_weight;
    logic                       in_fixed;

    logic [CNT_W-1:0] x5;
    logic [CNT_W-1:0] y5;
    logic [CNT_W-1:0] z5;
    logic [CNT_W-1:0] xm5;
    logic [CNT_W-1:0] zm5;

    logic             adv;
    logic             accept;
    logic             load_ok;
    logic             ram_we;
    addr_t            addr_c;
    addr_t            addr_ax;
    addr_t            addr_ay;
    addr_t            addr_az;
    logic [WORD_W-1:0] wr_word;
    logic [WORD_W-1:0] rd_c;
    logic [WORD_W-1:0] rd_ax;
    logic [WORD_W-1:0] rd_ay;
    logic [WORD_W-1:0] rd_az;

    meta_t meta1_reg;
    meta_t meta1_next;
    meta_t meta2_reg;
    meta_t meta2_next;
    meta_t meta3_reg;
    meta_t meta4_reg;

    field_t q_dx;
    field_t q_dy;
    field_t q_dz;
    field_t q_wx;
    field_t q_wy;
    field_t q_wz;

    logic skid_room;
    logic push;
    res_t push_data;
    res_t out_data;

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_count_reg <= clamp_count(CNT_W'(16), MAX_X);
            y_count_reg <= clamp_count(CNT_W'(16), MAX_Y);
            z_count_reg <= clamp_count(CNT_W'(16), MAX_Z);
            inv_reg     <= INV_W'(256);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_X_COUNT: x_count_reg <= clamp_count(cfg_data[CNT_W-1:0], MAX_X);
                REG_Y_COUNT: y_count_reg <= clamp_count(cfg_data[CNT_W-1:0], MAX_Y);
                REG_Z_COUNT: z_count_reg <= clamp_count(cfg_data[CNT_W-1:0], MAX_Z);
                REG_INV:     inv_reg     <= cfg_data;
                default:     ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // request decode and memory addressing
    // ------------------------------------------------------------------
    assign in_op     = s_tuser[0];
    assign in_x      = s_tdata[3:0];
    assign in_y      = s_tdata[7:4];
    assign in_z      = s_tdata[11:8];
    assign in_drift  = s_tdata[35:12];
    assign in_weight = s_tdata[59:36];
    assign in_fixed  = s_tdata[60];

    assign x5 = CNT_W'(in_x);
    assign y5 = CNT_W'(in_y);
    assign z5 = CNT_W'(in_z);

    // periodic wrap along x and z
    assign xm5 = (in_x == '0) ? x_count_reg - CNT_W'(1) : x5 - CNT_W'(1);
    assign zm5 = (in_z == '0) ? z_count_reg - CNT_W'(1) : z5 - CNT_W'(1);

    // row below; on row zero this wraps and the result is masked later
    assign addr_c  = make_addr(x5, y5, z5);
    assign addr_ax = make_addr(xm5, y5, z5);
    assign addr_ay = make_addr(x5, y5 - CNT_W'(1), z5);
    assign addr_az = make_addr(x5, y5, zm5);

    // whole pipeline moves while the skid has room
    assign adv      = skid_room;
    assign s_tready = adv;
    assign accept   = s_tvalid && s_tready;

    assign load_ok = (int'(in_x) < MAX_X) && (int'(in_y) < MAX_Y) && (int'(in_z) < MAX_Z);
    assign ram_we  = accept && (in_op == OP_LOAD) && load_ok;
    assign wr_word = {in_fixed, sat_pot(in_weight), sat_pot(in_drift)};

    // four copies so that all four reads of a compute happen in the same cycle
    pgf_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_ram_c (
        .clk(clk), .we(ram_we), .waddr(addr_c), .wdata(wr_word),
        .re(adv), .raddr(addr_c), .rdata(rd_c)
    );
    pgf_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_ram_ax (
        .clk(clk), .we(ram_we), .waddr(addr_c), .wdata(wr_word),
        .re(adv), .raddr(addr_ax), .rdata(rd_ax)
    );
    pgf_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_ram_ay (
        .clk(clk), .we(ram_we), .waddr(addr_c), .wdata(wr_word),
        .re(adv), .raddr(addr_ay), .rdata(rd_ay)
    );
    pgf_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_ram_az (
        .clk(clk), .we(ram_we), .waddr(addr_c), .wdata(wr_word),
        .re(adv), .raddr(addr_az), .rdata(rd_az)
    );

    // stage 1 control: live means inside the configured counts
    always_comb
    begin
        meta1_next.valid   = s_tvalid;
        meta1_next.compute = (in_op == OP_COMPUTE);
        meta1_next.live    = (x5 < x_count_reg) && (y5 < y_count_reg) && (z5 < z_count_reg);
        meta1_next.bottom  = (in_y == '0);
    end

    // stage 2 control: live now also needs a fixed point on row zero
    always_comb
    begin
        meta2_next      = meta1_reg;
        meta2_next.live = meta1_reg.live && !(meta1_reg.bottom && !rd_c[WORD_W-1]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            meta1_reg <= '0;
            meta2_reg <= '0;
            meta3_reg <= '0;
            meta4_reg <= '0;
        end
        else if (adv)
        begin
            meta1_reg <= meta1_next;
            meta2_reg <= meta2_next;
            meta3_reg <= meta2_reg;
            meta4_reg <= meta3_reg;
        end
    end

    // ------------------------------------------------------------------
    // six gradient lanes, drift word in the low bits, weighting above
    // ------------------------------------------------------------------
    pgf_lane u_lane_dx (
        .clk(clk), .en(adv), .centre(rd_c[POT_WIDTH-1:0]),
        .neighbour(rd_ax[POT_WIDTH-1:0]), .inv(inv_reg), .q(q_dx)
    );
    pgf_lane u_lane_dy (
        .clk(clk), .en(adv), .centre(rd_c[POT_WIDTH-1:0]),
        .neighbour(rd_ay[POT_WIDTH-1:0]), .inv(inv_reg), .q(q_dy)
    );
    pgf_lane u_lane_dz (
        .clk(clk), .en(adv), .centre(rd_c[POT_WIDTH-1:0]),
        .neighbour(rd_az[POT_WIDTH-1:0]), .inv(inv_reg), .q(q_dz)
    );
    pgf_lane u_lane_wx (
        .clk(clk), .en(adv), .centre(rd_c[2*POT_WIDTH-1:POT_WIDTH]),
        .neighbour(rd_ax[2*POT_WIDTH-1:POT_WIDTH]), .inv(inv_reg), .q(q_wx)
    );
    pgf_lane u_lane_wy (
        .clk(clk), .en(adv), .centre(rd_c[2*POT_WIDTH-1:POT_WIDTH]),
        .neighbour(rd_ay[2*POT_WIDTH-1:POT_WIDTH]), .inv(inv_reg), .q(q_wy)
    );
    pgf_lane u_lane_wz (
        .clk(clk), .en(adv), .centre(rd_c[2*POT_WIDTH-1:POT_WIDTH]),
        .neighbour(rd_az[2*POT_WIDTH-1:POT_WIDTH]), .inv(inv_reg), .q(q_wz)
    );

    // ------------------------------------------------------------------
    // result masking and output buffer
    // ------------------------------------------------------------------
    always_comb
    begin
        push_data.computed  = meta4_reg.live;
        push_data.drift_ex  = meta4_reg.live ? q_dx : '0;
        push_data.drift_ey  = (meta4_reg.live && !meta4_reg.bottom) ? q_dy : '0;
        push_data.drift_ez  = meta4_reg.live ? q_dz : '0;
        push_data.weight_ex = meta4_reg.live ? q_wx : '0;
        push_data.weight_ey = (meta4_reg.live && !meta4_reg.bottom) ? q_wy : '0;
        push_data.weight_ez = meta4_reg.live ? q_wz : '0;
    end

    // loads leave the pipeline here without a result
    assign push = adv && meta4_reg.valid && meta4_reg.compute;

    pgf_skid u_skid (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .push_data(push_data),
        .room(skid_room),
        .out_valid(m_tvalid),
        .out_ready(m_tready),
        .out_data(out_data)
    );

    assign m_tdata = {out_data.weight_ez, out_data.weight_ey, out_data.weight_ex,
                      out_data.drift_ez, out_data.drift_ey, out_data.drift_ex};
    assign m_tuser = out_data.computed;

`ifndef NO_ASSERTIONS
    // a full skid means the output register holds a result too
    a_stall_has_output: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("request side stalled with no result on offer");

    // a stalled pipeline keeps its last stage
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(meta4_reg))
        else $error("pipeline moved while stalled");

    // results not computed carry all-zero fields
    a_uncomputed_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
        else $error("uncomputed result with nonzero fields");

    // row-zero results have no y component
    a_bottom_no_ey: assert property (@(posedge clk) disable iff (!rst_n)
        (push && meta4_reg.bottom) |-> (push_data.drift_ey == '0 && push_data.weight_ey == '0))
        else $error("row-zero result with a y component");
`endif

endmodule
